// ===== rtl/nfcfb_pkg.sv =====
// Shared constants and helpers for the NFC command frame builder.
package nfcfb_pkg;

  localparam int unsigned MaxPayload = 254;

  localparam logic [7:0] PrefixWrite = 8'h01;
  localparam logic [7:0] Preamble    = 8'h00;
  localparam logic [7:0] StartCode   = 8'hFF;
  localparam logic [7:0] DirHost     = 8'hD4;
  localparam logic [7:0] Postamble   = 8'h00;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 1;

  localparam logic [CfgIdxW-1:0] RegReverseBits = 1'd0;
  localparam logic [CfgIdxW-1:0] RegSendPrefix  = 1'd1;

  function automatic logic [7:0] flip8(input logic [7:0] v);
    logic [7:0] r;
    for (int p = 0; p < 8; p++) begin
      r[7-p] = v[p];
    end
    return r;
  endfunction

endpackage

// ===== rtl/nfc_command_frame_builder_unit.sv =====
// Top level of the NFC command frame builder: header, payload and trailer sequencing.
//
// The block wraps a stream of command bytes into a host-to-controller normal
// information frame and sends it one byte per cycle while the output is not
// stalled. An item that opens a frame (first_of_frame high) produces the
// optional 0x01 prefix, 00 00 FF, LEN, LCS, D4 and its own command byte,
// followed by DCS and postamble when that byte is also the last of the frame;
// a payload byte in the middle of a frame produces only itself, and the last
// payload byte produces the byte, DCS and postamble. Each byte passes through
// the single output register, which takes one byte per cycle when it is not
// stalled. Input is accepted in the same cycle the previous item hands over
// its final byte, so payload bytes stream at one per cycle while the output
// is not stalled. Items with first_of_frame low while no frame is open are
// accepted and dropped. A frame length of 0 is taken as 1 and one above 254
// as 254. A new first item abandons an open frame without trailer.
// Configuration writes are always ready; register 0 selects bit reversal of
// every emitted byte, register 1 enables the prefix.
module nfc_command_frame_builder_unit
  import nfcfb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          cmd_byte,
  input  logic [7:0]          frame_len,
  input  logic                first_of_frame,
  // output channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                frame_end,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_PREFIX, S_PRE0, S_PRE1, S_START, S_LEN, S_LCS, S_DIR, S_DATA, S_DCS, S_POST
  } step_t;

  // configuration registers
  logic reverse_bits;
  logic send_prefix;

  // frame state
  logic [7:0] bytes_left;
  logic [7:0] data_sum;

  // item register
  logic       item_valid;
  logic [7:0] item_byte;
  logic [7:0] item_len;
  logic [7:0] item_dcs;
  logic       item_last;
  step_t      step;

  logic       in_take;
  logic       out_free;
  logic       emit;
  logic       item_done;
  logic       item_load;
  logic [7:0] cnt_clamp;
  logic [7:0] sum_next;
  logic [7:0] bytes_left_next;
  logic       last_next;
  logic [7:0] emit_byte;

  assign cfg_ready = 1'b1;

  assign out_free  = !out_valid || !out_stall;
  assign emit      = item_valid && out_free;
  assign item_done = emit && ((step == S_DATA && !item_last) || step == S_POST);
  assign in_stall  = item_valid && !item_done;
  assign in_take   = in_valid && !in_stall;

  always_comb begin
    cnt_clamp = frame_len;
    if (frame_len == 8'd0) begin
      cnt_clamp = 8'd1;
    end else if (frame_len > 8'(MaxPayload)) begin
      cnt_clamp = 8'(MaxPayload);
    end
    if (first_of_frame) begin
      sum_next        = cmd_byte;
      bytes_left_next = cnt_clamp - 8'd1;
    end else begin
      sum_next        = data_sum + cmd_byte;
      bytes_left_next = bytes_left - 8'd1;
    end
    last_next = (bytes_left_next == 8'd0);
    item_load = in_take && (first_of_frame || bytes_left != 8'd0);
  end

  always_comb begin
    case (step)
      S_PREFIX: emit_byte = PrefixWrite;
      S_PRE0:   emit_byte = Preamble;
      S_PRE1:   emit_byte = Preamble;
      S_START:  emit_byte = StartCode;
      S_LEN:    emit_byte = item_len;
      S_LCS:    emit_byte = 8'd0 - item_len;
      S_DIR:    emit_byte = DirHost;
      S_DATA:   emit_byte = item_byte;
      S_DCS:    emit_byte = item_dcs;
      S_POST:   emit_byte = Postamble;
      default:  emit_byte = Postamble;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reverse_bits <= 1'b1;
      send_prefix  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == RegReverseBits) begin
        reverse_bits <= cfg_data[0];
      end else if (cfg_index == RegSendPrefix) begin
        send_prefix <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= 8'd0;
      data_sum   <= 8'd0;
      item_valid <= 1'b0;
      step       <= S_DATA;
      out_valid  <= 1'b0;
    end else begin
      // advance the sequencer on each emitted byte
      if (emit && !item_load) begin
        case (step)
          S_PREFIX: step <= S_PRE0;
          S_PRE0:   step <= S_PRE1;
          S_PRE1:   step <= S_START;
          S_START:  step <= S_LEN;
          S_LEN:    step <= S_LCS;
          S_LCS:    step <= S_DIR;
          S_DIR:    step <= S_DATA;
          S_DATA:   step <= S_DCS;
          S_DCS:    step <= S_POST;
          S_POST:   step <= S_DATA;
          default:  step <= S_DATA;
        endcase
      end
      if (item_load) begin
        item_valid <= 1'b1;
        bytes_left <= bytes_left_next;
        data_sum   <= last_next ? 8'd0 : sum_next;
        if (first_of_frame) begin
          step <= send_prefix ? S_PREFIX : S_PRE0;
        end else begin
          step <= S_DATA;
        end
      end else if (item_done) begin
        item_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (item_load) begin
      item_byte <= cmd_byte;
      item_len  <= cnt_clamp + 8'd1;
      item_dcs  <= 8'd0 - (DirHost + sum_next);
      item_last <= last_next;
    end
    if (emit) begin
      out_byte  <= reverse_bits ? flip8(emit_byte) : emit_byte;
      frame_end <= (step == S_POST);
    end
  end

  a_sum_idle: assert property (@(posedge clk) disable iff (rst)
    bytes_left == 8'd0 |-> data_sum == 8'd0)
    else $error("data sum left over with no frame open");

  a_post_end: assert property (@(posedge clk) disable iff (rst)
    emit && step == S_POST |=> out_valid && frame_end && out_byte == Postamble)
    else $error("postamble not flagged as frame end");

  a_end_only_post: assert property (@(posedge clk) disable iff (rst)
    emit && step != S_POST |=> !frame_end)
    else $error("frame end on a byte other than the postamble");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item_valid)
    else $error("input stalled with no request in progress");

endmodule
